### rtl/pit_pkg.sv
// shared types and constants for the interval timer
package pit_pkg;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   localparam logic [1:0] PORT_CMD  = 2'd3;

   localparam logic [1:0] ACC_LATCH = 2'd0;
   localparam logic [1:0] ACC_LO    = 2'd1;
   localparam logic [1:0] ACC_HI    = 2'd2;
   localparam logic [1:0] ACC_LOHI  = 2'd3;

   localparam logic [2:0] MODE_0    = 3'd0;
   localparam logic [2:0] MODE_2    = 3'd2;
   localparam logic [2:0] MODE_3    = 3'd3;
   localparam logic [2:0] MODE_FOLD = 3'd4;

   localparam int NUM_OUT = 3;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] port_offset;
      logic       is_io;
      logic [7:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic       rd_hit;
      logic       wr_hit;
      logic       cmd_hit;
      logic       tick;
      logic [7:0] data;
   } chan_ctrl_type;

   typedef struct packed {
      logic       level_in;
      logic [7:0] rd_data;
   } chan_stat_type;

endpackage

### rtl/pit_if.sv
// request and response channel interfaces
interface pit_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [1:0] port_offset;
   logic       is_io;
   logic [7:0] write_data;

   modport source (output valid, cmd, port_offset, is_io, write_data, input ready);
   modport sink   (input valid, cmd, port_offset, is_io, write_data, output ready);
endinterface

interface pit_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       read_valid;
   logic       write_accepted;
   logic       irq_raise;
   logic [2:0] channel_outputs;

   modport source (output valid, read_data, read_valid, write_accepted, irq_raise,
                   channel_outputs, input ready);
   modport sink   (input valid, read_data, read_valid, write_accepted, irq_raise,
                   channel_outputs, output ready);
endinterface

### rtl/pit_channel.sv
// one timer channel: count state, byte access and countdown
module pit_channel
   import pit_pkg::*;
#(
   parameter logic [1:0] CH_IDX = 2'd0
) (
   input  logic          clock,
   input  logic          reset,
   input  chan_ctrl_type ctrl,
   output chan_stat_type stat
);

   logic [15:0] reload_ff, reload_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] latched_ff, latched_in;
   logic [1:0]  acc_ff, acc_in;
   logic [2:0]  mode_ff, mode_in;
   logic        level_ff, level_in;
   logic        phase_ff, phase_in;
   logic        latch_flag_ff, latch_flag_in;
   logic        rd_high_ff, rd_high_in;
   logic        wr_high_ff, wr_high_in;
   logic [7:0]  rd_data;

   always_comb begin
      logic [15:0] src;
      logic [15:0] step;
      logic        high;
      logic [2:0]  new_mode;
      reload_in     = reload_ff;
      count_in      = count_ff;
      latched_in    = latched_ff;
      acc_in        = acc_ff;
      mode_in       = mode_ff;
      level_in      = level_ff;
      phase_in      = phase_ff;
      latch_flag_in = latch_flag_ff;
      rd_high_in    = rd_high_ff;
      wr_high_in    = wr_high_ff;
      rd_data       = 8'd0;
      src           = latch_flag_ff ? latched_ff : count_ff;
      step          = 16'd0;
      high          = 1'b0;
      new_mode      = ctrl.data[3:1];

      if (ctrl.rd_hit) begin
         case (acc_ff)
            ACC_LO: begin
               latch_flag_in = 1'b0;
               rd_data       = src[7:0];
            end
            ACC_HI: begin
               latch_flag_in = 1'b0;
               rd_data       = src[15:8];
            end
            default: begin
               if (!rd_high_ff) begin
                  rd_high_in = 1'b1;
                  rd_data    = src[7:0];
               end else begin
                  rd_high_in    = 1'b0;
                  latch_flag_in = 1'b0;
                  rd_data       = src[15:8];
               end
            end
         endcase
      end else if (ctrl.wr_hit) begin
         case (acc_ff)
            ACC_LO:  high = 1'b0;
            ACC_HI:  high = 1'b1;
            default: begin
               high       = wr_high_ff;
               wr_high_in = !wr_high_ff;
            end
         endcase
         if (high) reload_in = {ctrl.data, reload_ff[7:0]};
         else      reload_in = {reload_ff[15:8], ctrl.data};
         if ((acc_ff == ACC_LO || acc_ff == ACC_HI || high) && mode_ff == MODE_0) begin
            level_in = 1'b1;
            count_in = reload_in;
         end
      end else if (ctrl.cmd_hit) begin
         if (ctrl.data[5:4] == ACC_LATCH) begin
            latched_in    = count_ff;
            latch_flag_in = 1'b1;
            rd_high_in    = 1'b0;
         end else begin
            if (new_mode inside {3'd6, 3'd7}) new_mode = new_mode - MODE_FOLD;
            acc_in        = ctrl.data[5:4];
            mode_in       = new_mode;
            latch_flag_in = 1'b0;
            rd_high_in    = 1'b0;
            wr_high_in    = 1'b0;
            if (new_mode == MODE_0) level_in = 1'b0;
         end
      end else if (ctrl.tick) begin
         case (mode_ff)
            MODE_0: begin
               if (count_ff != 16'd0 && level_ff) begin
                  count_in = count_ff - 16'd1;
                  level_in = 1'b1;
               end else begin
                  level_in = 1'b0;
               end
            end
            MODE_2: begin
               if (count_ff != 16'd1) begin
                  count_in = count_ff - 16'd1;
                  level_in = 1'b1;
               end else begin
                  level_in = 1'b0;
               end
            end
            MODE_3: begin
               step     = count_ff[0] ? 16'd1 : 16'd2;
               count_in = count_ff - step;
               if (count_in != 16'd0) begin
                  level_in = 1'b1;
               end else if (phase_ff) begin
                  phase_in = 1'b0;
               end else begin
                  level_in = 1'b0;
                  phase_in = 1'b1;
               end
            end
            default: ;
         endcase
         if (!level_in && (mode_ff == MODE_0 || mode_ff == MODE_2 || mode_ff == MODE_3))
            count_in = reload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff     <= '0;
         count_ff      <= '0;
         latched_ff    <= '0;
         acc_ff        <= ACC_LATCH;
         mode_ff       <= MODE_0;
         level_ff      <= 1'b0;
         phase_ff      <= 1'b0;
         latch_flag_ff <= 1'b0;
         rd_high_ff    <= 1'b0;
         wr_high_ff    <= 1'b0;
      end else begin
         reload_ff     <= reload_in;
         count_ff      <= count_in;
         latched_ff    <= latched_in;
         acc_ff        <= acc_in;
         mode_ff       <= mode_in;
         level_ff      <= level_in;
         phase_ff      <= phase_in;
         latch_flag_ff <= latch_flag_in;
         rd_high_ff    <= rd_high_in;
         wr_high_ff    <= wr_high_in;
      end
   end

   assign stat.level_in = level_in;
   assign stat.rd_data  = rd_data;

`ifndef SYNTHESIS
   a_mode_stored: assert property (@(posedge clock) disable iff (reset)
      !(mode_ff == 3'd6 || mode_ff == 3'd7))
      else $error("channel %0d holds an unfolded mode", CH_IDX);
   a_rd_quiet: assert property (@(posedge clock) disable iff (reset)
      !ctrl.rd_hit |-> rd_data == 8'd0)
      else $error("channel %0d drives read data without a read", CH_IDX);
   a_mode0_load: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_hit && mode_ff == MODE_0 && (acc_ff == ACC_LO || acc_ff == ACC_HI)
      |=> level_ff && count_ff == reload_ff)
      else $error("channel %0d mode 0 load did not arm", CH_IDX);
`endif

endmodule

### rtl/programmable_interval_timer.sv
// top level of the three-channel interval timer
//
//   channel  dir  payload
//   req_ch   in   cmd, port_offset, is_io, write_data
//   rsp_ch   out  read_data, read_valid, write_accepted, irq_raise, channel_outputs
//
// one request per cycle while the response side keeps up; a request passes the input register,
// then the channel state update and response register in one pass
// synchronous reset clears all channel state to zero
// the response register lets a new request in while a response waits; a stalled
// response holds the input register, and req_ch.ready drops only when both are full
module programmable_interval_timer
   import pit_pkg::*;
#(
   parameter int NUM_CHANNELS = 3
) (
   input logic       clock,
   input logic       reset,
   pit_req_if.sink   req_ch,
   pit_rsp_if.source rsp_ch
);

   localparam logic [1:0] NUM_PORTS = 2'(NUM_CHANNELS);

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_read_data_ff;
   logic          rsp_read_valid_ff, rsp_write_acc_ff, rsp_irq_ff;
   logic [2:0]    rsp_outs_ff;
   logic          advance, fire, req_take;
   logic [7:0]    rd_or;
   logic [2:0]    outs_in;
   logic          data_port;
   chan_stat_type stat [NUM_CHANNELS];

   assign advance   = !rsp_valid_ff || rsp_ch.ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take  = req_ch.valid && req_ch.ready;
   assign data_port = s1_item_ff.port_offset < NUM_PORTS;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)  s1_valid_in = 1'b1;
      else if (fire) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (fire)              rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.cmd         <= cmd_type'(req_ch.cmd);
         s1_item_ff.port_offset <= req_ch.port_offset;
         s1_item_ff.is_io       <= req_ch.is_io;
         s1_item_ff.write_data  <= req_ch.write_data;
      end
   end

   for (genvar g = 0; g < NUM_OUT; g++) begin : g_chan
      if (g < NUM_CHANNELS) begin : g_on
         chan_ctrl_type ctrl;
         assign ctrl.rd_hit  = fire && s1_item_ff.cmd == CMD_READ && s1_item_ff.is_io
                               && s1_item_ff.port_offset == 2'(g);
         assign ctrl.wr_hit  = fire && s1_item_ff.cmd == CMD_WRITE && s1_item_ff.is_io
                               && s1_item_ff.port_offset == 2'(g);
         assign ctrl.cmd_hit = fire && s1_item_ff.cmd == CMD_WRITE && s1_item_ff.is_io
                               && s1_item_ff.port_offset == PORT_CMD
                               && s1_item_ff.write_data[7:6] == 2'(g);
         assign ctrl.tick    = fire && s1_item_ff.cmd == CMD_TICK;
         assign ctrl.data    = s1_item_ff.write_data;

         pit_channel #(.CH_IDX(2'(g))) u_channel (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .stat  (stat[g])
         );
         assign outs_in[g] = stat[g].level_in;
      end else begin : g_off
         assign outs_in[g] = 1'b0;
      end
   end

   always_comb begin
      rd_or = 8'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) rd_or = rd_or | stat[i].rd_data;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_read_data_ff  <= rd_or;
         rsp_read_valid_ff <= s1_item_ff.cmd == CMD_READ && s1_item_ff.is_io && data_port;
         rsp_write_acc_ff  <= s1_item_ff.cmd == CMD_WRITE && s1_item_ff.is_io
                              && (s1_item_ff.port_offset == PORT_CMD || data_port);
         rsp_irq_ff        <= s1_item_ff.cmd == CMD_TICK && !outs_in[0];
         rsp_outs_ff       <= outs_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_data       = rsp_read_data_ff;
   assign rsp_ch.read_valid      = rsp_read_valid_ff;
   assign rsp_ch.write_accepted  = rsp_write_acc_ff;
   assign rsp_ch.irq_raise       = rsp_irq_ff;
   assign rsp_ch.channel_outputs = rsp_outs_ff;

`ifndef SYNTHESIS
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_read_valid_ff && rsp_write_acc_ff))
      else $error("response flags both a read and a write");
   a_irq_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_irq_ff |-> !rsp_outs_ff[0])
      else $error("interrupt with channel 0 output high");
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_read_valid_ff |-> rsp_read_data_ff == 8'd0)
      else $error("read data without a read hit");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input register lost a request during a stall");
`endif

endmodule

### sim/pit_response_checker.sv
// timer response checker: predicts every response from the accepted requests and compares them
`timescale 1ns / 1ps

module pit_response_checker
   import pit_pkg::*;
#(
   parameter int NUM_CHANNELS = 3
) (
   input  logic clock,
   input  logic reset,
   pit_req_if   req_mon,
   pit_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       write_accepted;
      logic       irq_raise;
      logic [2:0] channel_outputs;
   } timer_result_type;

   logic [15:0] reload_val [NUM_CHANNELS];
   logic [15:0] count      [NUM_CHANNELS];
   logic [15:0] latched    [NUM_CHANNELS];
   logic [1:0]  access     [NUM_CHANNELS];
   logic [2:0]  op_mode    [NUM_CHANNELS];
   logic        level      [NUM_CHANNELS];
   logic        wave_half  [NUM_CHANNELS];
   logic        latch_held [NUM_CHANNELS];
   logic        read_hi    [NUM_CHANNELS];
   logic        write_hi   [NUM_CHANNELS];

   timer_result_type expected_rsp_q[$];
   int mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic logic [7:0] read_count(int c);
      logic [15:0] src;
      src = latch_held[c] ? latched[c] : count[c];
      case (access[c])
         ACC_LO: begin
            latch_held[c] = 1'b0;
            return src[7:0];
         end
         ACC_HI: begin
            latch_held[c] = 1'b0;
            return src[15:8];
         end
         default: begin
            if (!read_hi[c]) begin
               read_hi[c] = 1'b1;
               return src[7:0];
            end
            read_hi[c]    = 1'b0;
            latch_held[c] = 1'b0;
            return src[15:8];
         end
      endcase
   endfunction

   function automatic void load_byte(int c, logic [7:0] d);
      logic hi;
      if (access[c] == ACC_LO) begin
         hi = 1'b0;
      end else if (access[c] == ACC_HI) begin
         hi = 1'b1;
      end else begin
         hi          = write_hi[c];
         write_hi[c] = !hi;
      end
      if (hi) begin
         reload_val[c][15:8] = d;
      end else begin
         reload_val[c][7:0] = d;
      end
      if ((access[c] == ACC_LO || access[c] == ACC_HI || hi) && op_mode[c] == MODE_0) begin
         level[c] = 1'b1;
         count[c] = reload_val[c];
      end
   endfunction

   function automatic void apply_command(logic [7:0] d);
      int         c;
      logic [1:0] acc;
      logic [2:0] md;
      c   = int'(d[7:6]);
      acc = d[5:4];
      md  = d[3:1];
      if (c >= NUM_CHANNELS) return;
      if (acc == ACC_LATCH) begin
         latched[c]    = count[c];
         latch_held[c] = 1'b1;
         read_hi[c]    = 1'b0;
         return;
      end
      if (md >= MODE_2 + MODE_FOLD) md = md - MODE_FOLD;
      access[c]     = acc;
      op_mode[c]    = md;
      latch_held[c] = 1'b0;
      read_hi[c]    = 1'b0;
      write_hi[c]   = 1'b0;
      if (md == MODE_0) level[c] = 1'b0;
   endfunction

   function automatic void tick_all();
      logic [2:0] m;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         m = op_mode[c];
         if (m == MODE_0) begin
            if (count[c] != 16'd0 && level[c]) begin
               count[c] = count[c] - 16'd1;
               level[c] = 1'b1;
            end else begin
               level[c] = 1'b0;
            end
         end else if (m == MODE_2) begin
            if (count[c] != 16'd1) begin
               count[c] = count[c] - 16'd1;
               level[c] = 1'b1;
            end else begin
               level[c] = 1'b0;
            end
         end else if (m == MODE_3) begin
            count[c] = count[c] - (count[c][0] ? 16'd1 : 16'd2);
            if (count[c] != 16'd0) begin
               level[c] = 1'b1;
            end else if (wave_half[c]) begin
               wave_half[c] = 1'b0;
            end else begin
               level[c]     = 1'b0;
               wave_half[c] = 1'b1;
            end
         end
         if (!level[c] && (m == MODE_0 || m == MODE_2 || m == MODE_3)) count[c] = reload_val[c];
      end
   endfunction

   function automatic timer_result_type advance_timer(req_item_type rq);
      timer_result_type r;
      r = '0;
      case (rq.cmd)
         CMD_READ: begin
            if (rq.is_io && rq.port_offset != PORT_CMD && rq.port_offset < NUM_CHANNELS) begin
               r.read_data  = read_count(int'(rq.port_offset));
               r.read_valid = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (rq.is_io) begin
               if (rq.port_offset == PORT_CMD) begin
                  apply_command(rq.write_data);
                  r.write_accepted = 1'b1;
               end else if (rq.port_offset < NUM_CHANNELS) begin
                  load_byte(int'(rq.port_offset), rq.write_data);
                  r.write_accepted = 1'b1;
               end
            end
         end
         CMD_TICK: begin
            tick_all();
            r.irq_raise = !level[0];
         end
         default: ;
      endcase
      for (int c = 0; c < NUM_CHANNELS; c++) r.channel_outputs[c] = level[c];
      return r;
   endfunction

   always @(posedge clock) begin
      req_item_type     rq;
      timer_result_type want;
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            reload_val[c] = '0;
            count[c]      = '0;
            latched[c]    = '0;
            access[c]     = '0;
            op_mode[c]    = '0;
            level[c]      = 1'b0;
            wave_half[c]  = 1'b0;
            latch_held[c] = 1'b0;
            read_hi[c]    = 1'b0;
            write_hi[c]   = 1'b0;
         end
         expected_rsp_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            rq.cmd         = cmd_type'(req_mon.cmd);
            rq.port_offset = req_mon.port_offset;
            rq.is_io       = req_mon.is_io;
            rq.write_data  = req_mon.write_data;
            expected_rsp_q.push_back(advance_timer(rq));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no request pending", rsp_mon.read_data, 8'h00);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_mon.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_mon.read_data, want.read_data);
               if (rsp_mon.read_valid !== want.read_valid)
                  report_mismatch("read_valid", 8'(rsp_mon.read_valid), 8'(want.read_valid));
               if (rsp_mon.write_accepted !== want.write_accepted)
                  report_mismatch("write_accepted", 8'(rsp_mon.write_accepted),
                                  8'(want.write_accepted));
               if (rsp_mon.irq_raise !== want.irq_raise)
                  report_mismatch("irq_raise", 8'(rsp_mon.irq_raise), 8'(want.irq_raise));
               if (rsp_mon.channel_outputs !== want.channel_outputs)
                  report_mismatch("channel_outputs", 8'(rsp_mon.channel_outputs),
                                  8'(want.channel_outputs));
            end
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

### sim/programmable_interval_timer_tb.sv
// testbench top: clock, reset, request stimulus, response flow control and the verdict
`timescale 1ns / 1ps

module programmable_interval_timer_tb;
   import pit_pkg::*;

   localparam int NUM_CHANNELS    = 3;
   localparam int HOLD_CYCLES     = 60;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int ITEMS_PER_PHASE = 260;

   localparam logic [2:0] MODE_1 = 3'd1;
   localparam logic [2:0] MODE_4 = 3'd4;
   localparam logic [2:0] MODE_5 = 3'd5;

   typedef enum int {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_BACKPRESSURE
   } idle_phase_type;

   logic           clock;
   logic           reset;
   int             fail_count;
   int             pending_count;
   int             sent = 0;
   int             quiet_cycles = 0;
   idle_phase_type phase = PH_FREE;

   pit_req_if req_ch();
   pit_rsp_if rsp_ch();

   programmable_interval_timer #(.NUM_CHANNELS(NUM_CHANNELS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pit_response_checker #(.NUM_CHANNELS(NUM_CHANNELS)) response_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int sender_idle_pct(idle_phase_type p);
      case (p)
         PH_SEND_IDLE: return 65;
         PH_BOTH:      return 28;
         default:      return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(idle_phase_type p);
      case (p)
         PH_RECV_STALL: return 65;
         PH_BOTH:       return 28;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [7:0] command_byte(int ch, logic [1:0] acc, logic [2:0] mode);
      return {2'(ch), acc, mode, 1'($urandom)};
   endfunction

   task automatic send(cmd_type cmd, logic [1:0] port, logic io, logic [7:0] data);
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.port_offset <= port;
      req_ch.is_io       <= io;
      req_ch.write_data  <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      while ($urandom_range(99) < sender_idle_pct(phase)) begin
         req_ch.valid       <= 1'b0;
         req_ch.cmd         <= 2'($urandom);
         req_ch.port_offset <= 2'($urandom);
         req_ch.is_io       <= 1'($urandom);
         req_ch.write_data  <= 8'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic io_write(logic [1:0] port, logic [7:0] data);
      send(CMD_WRITE, port, 1'b1, data);
   endtask

   task automatic io_read(logic [1:0] port);
      send(CMD_READ, port, 1'b1, 8'($urandom));
   endtask

   task automatic tick();
      send(CMD_TICK, 2'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic latch_count(int ch);
      io_write(PORT_CMD, {2'(ch), ACC_LATCH, 4'($urandom)});
   endtask

   task automatic directed_requests();
      io_read(2'd0);
      io_read(PORT_CMD);
      io_write(2'd0, 8'hFF);
      io_write(2'd0, 8'h00);
      tick();
      send(CMD_WRITE, 2'd1, 1'b0, 8'hA5);
      send(CMD_NOP, 2'd2, 1'b1, 8'h5A);
      send(CMD_READ, 2'd0, 1'b0, 8'h00);
      io_write(PORT_CMD, 8'hFF);
      latch_count(0);
      tick();
      io_read(2'd0);
      io_read(2'd0);
      io_write(PORT_CMD, command_byte(1, ACC_LO, MODE_2));
      io_write(2'd1, 8'h02);
      io_write(PORT_CMD, command_byte(2, ACC_HI, MODE_3 + MODE_FOLD));
      io_write(2'd2, 8'h00);
      io_write(PORT_CMD, command_byte(0, ACC_LOHI, MODE_2 + MODE_FOLD));
      io_write(2'd0, 8'h03);
      io_write(2'd0, 8'h00);
      repeat (3) tick();
      io_write(PORT_CMD, command_byte(0, ACC_LOHI, MODE_1));
      tick();
      io_write(PORT_CMD, command_byte(1, ACC_HI, MODE_4));
      io_write(PORT_CMD, command_byte(2, ACC_LO, MODE_5));
      tick();
      io_read(2'd1);
      io_read(2'd2);
   endtask

   // command, reload value, then a run of ticks with reads and latches mixed in
   task automatic program_channel();
      int          ch;
      int          pch;
      logic [1:0]  acc;
      logic [15:0] value;
      ch    = ($urandom_range(19) == 0) ? 3 : $urandom_range(NUM_CHANNELS - 1);
      pch   = (ch >= NUM_CHANNELS) ? $urandom_range(NUM_CHANNELS - 1) : ch;
      acc   = 2'($urandom_range(ACC_LO, ACC_LOHI));
      value = ($urandom_range(99) < 80) ? 16'($urandom_range(12)) : 16'($urandom);
      io_write(PORT_CMD, command_byte(ch, acc, 3'($urandom)));
      if (acc == ACC_LOHI) begin
         io_write(2'(pch), value[7:0]);
         io_write(2'(pch), value[15:8]);
      end else begin
         io_write(2'(pch), value[7:0]);
      end
      repeat ($urandom_range(1, 30)) begin
         tick();
         case ($urandom_range(9))
            0: io_read(2'(pch));
            1: latch_count(pch);
            default: ;
         endcase
      end
   endtask

   task automatic random_requests(int count);
      int stop;
      int ch;
      stop = sent + count;
      while (sent < stop) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: program_channel();
            11, 12, 13: begin
               ch = $urandom_range(NUM_CHANNELS - 1);
               latch_count(ch);
               repeat ($urandom_range(1, 2)) io_read(2'(ch));
            end
            14, 15, 16: repeat ($urandom_range(1, 20)) tick();
            default: begin
               repeat ($urandom_range(1, 5))
                  send(cmd_type'($urandom_range(3)), 2'($urandom), 1'($urandom), 8'($urandom));
            end
         endcase
      end
   endtask

   // response side flow control, with one long hold-off to back up the block
   initial begin
      logic held_once;
      held_once = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_BACKPRESSURE && !held_once) begin
            held_once = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct(phase));
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      idle_phase_type order [5];
      order = '{PH_FREE, PH_SEND_IDLE, PH_BACKPRESSURE, PH_RECV_STALL, PH_BOTH};
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_NOP;
      req_ch.port_offset <= 2'd0;
      req_ch.is_io       <= 1'b0;
      req_ch.write_data  <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      directed_requests();
      foreach (order[i]) begin
         phase = order[i];
         random_requests(ITEMS_PER_PHASE);
      end
      phase = PH_FREE;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
